@@ rtl/core/offline_failsafe_valve_cycler_macros.svh @@
// Assertion macros shared by the valve cycler RTL.
// Setting ASSERT_OFF turns every check into nothing.
`ifndef OFFLINE_FAILSAFE_VALVE_CYCLER_MACROS_SVH
`define OFFLINE_FAILSAFE_VALVE_CYCLER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define OFVC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("valve cycler check failed");
// Next-cycle implication, checked outside reset.
`define OFVC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("valve cycler check failed");
`else
`define OFVC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OFVC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/ofvc_pkg.sv @@
package ofvc_pkg;

    localparam int unsigned COIL_W   = 3;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned SECS_W   = 16;
    localparam int unsigned MS_PER_SECOND = 1000;
    // 65535 s in milliseconds fits in 26 bits.
    localparam int unsigned PHASE_MS_W = 26;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_REPLAY_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPRAY_SECONDS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_SECONDS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS_ACTIVE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFLINE_CONFIRM_MS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAIN_VALVE_COIL    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FOG_VALVE_COIL     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS_VALVE_COIL  = 3'd7;

    // Register reset values.
    localparam logic [TIME_W-1:0] RST_OFFLINE_CONFIRM_MS = 32'd30000;
    localparam logic [COIL_W-1:0] RST_MAIN_VALVE_COIL    = 3'd0;
    localparam logic [COIL_W-1:0] RST_FOG_VALVE_COIL     = 3'd1;
    localparam logic [COIL_W-1:0] RST_BYPASS_VALVE_COIL  = 3'd2;

    // Input item kinds carried in tuser.
    localparam logic OP_LINK_UPDATE = 1'b0;
    localparam logic OP_SERVER_CMD  = 1'b1;

    // Stream widths.
    localparam int unsigned S_TDATA_W = 40;  // 37 bits of fields padded to bytes
    localparam int unsigned M_TDATA_W = 8;   // 4 bits of fields padded to bytes

    typedef struct packed {
        logic [COIL_W-1:0] coil_index;
        logic              coil_on;
        logic              last;
    } t_result;

endpackage

@@ rtl/core/offline_failsafe_valve_cycler.sv @@
// Results are written into a registered queue and offered on the master side from its head.
// Throughput: one input item per cycle while each item yields at most one result and
// the master side takes them; an offline confirmation yields two results, both queued.
// Reset (i_rst_n low, synchronous): link assumed up, no countdown, replay stopped,
// registers at their reset values and the result queue empty.
`include "offline_failsafe_valve_cycler_macros.svh"

module offline_failsafe_valve_cycler
    import ofvc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // Configuration write port.
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,

    // Input items.
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // Fields from bit 0: link_up[0], now_ms[32:1], cmd_coil[35:33], cmd_on[36], zeros.
    input  logic [S_TDATA_W-1:0]   i_s_axis_tdata,
    // Fields from bit 0: operation[0].
    input  logic                   i_s_axis_tuser,

    // Valve commands.
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // Fields from bit 0: coil_index[2:0], coil_on[3], zeros.
    output logic [M_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                   o_m_axis_tlast
);

    // ------------------------------------------------------------------
    // Configuration registers. The phase lengths are held in milliseconds,
    // converted once when they are written, so that the item path only
    // subtracts and compares. A zero length in seconds is zero in ms too.
    // ------------------------------------------------------------------
    logic                  r_replay_enable;
    logic [PHASE_MS_W-1:0] r_spray_ms;
    logic [PHASE_MS_W-1:0] r_stop_ms;
    logic                  r_bypass_active;
    logic [TIME_W-1:0]     r_confirm_ms;
    logic [COIL_W-1:0]     r_main_coil;
    logic [COIL_W-1:0]     r_fog_coil;
    logic [COIL_W-1:0]     r_bypass_coil;
    logic [PHASE_MS_W-1:0] n_cfg_ms;

    assign n_cfg_ms = PHASE_MS_W'(i_cfg_wdata[SECS_W-1:0]) * PHASE_MS_W'(MS_PER_SECOND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_replay_enable <= 1'b0;
            r_spray_ms      <= '0;
            r_stop_ms       <= '0;
            r_bypass_active <= 1'b0;
            r_confirm_ms    <= RST_OFFLINE_CONFIRM_MS;
            r_main_coil     <= RST_MAIN_VALVE_COIL;
            r_fog_coil      <= RST_FOG_VALVE_COIL;
            r_bypass_coil   <= RST_BYPASS_VALVE_COIL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_REPLAY_ENABLE:      r_replay_enable <= i_cfg_wdata[0];
                REG_SPRAY_SECONDS:      r_spray_ms      <= n_cfg_ms;
                REG_STOP_SECONDS:       r_stop_ms       <= n_cfg_ms;
                REG_BYPASS_ACTIVE:      r_bypass_active <= i_cfg_wdata[0];
                REG_OFFLINE_CONFIRM_MS: r_confirm_ms    <= i_cfg_wdata[TIME_W-1:0];
                REG_MAIN_VALVE_COIL:    r_main_coil     <= i_cfg_wdata[COIL_W-1:0];
                REG_FOG_VALVE_COIL:     r_fog_coil      <= i_cfg_wdata[COIL_W-1:0];
                REG_BYPASS_VALVE_COIL:  r_bypass_coil   <= i_cfg_wdata[COIL_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input field unpacking.
    // ------------------------------------------------------------------
    logic              in_op;
    logic              in_link_up;
    logic [TIME_W-1:0] in_now;
    logic [COIL_W-1:0] in_cmd_coil;
    logic              in_cmd_on;

    assign in_op       = i_s_axis_tuser;
    assign in_link_up  = i_s_axis_tdata[0];
    assign in_now      = i_s_axis_tdata[32:1];
    assign in_cmd_coil = i_s_axis_tdata[35:33];
    assign in_cmd_on   = i_s_axis_tdata[36];

    // ------------------------------------------------------------------
    // Link and replay state.
    // ------------------------------------------------------------------
    logic              r_prev_link_up;
    logic [TIME_W-1:0] r_disconnect_start;
    logic              r_offline_confirmed;
    logic              r_replay_running;
    logic              r_replay_open;
    logic [TIME_W-1:0] r_phase_start;

    logic              n_prev_link_up;
    logic [TIME_W-1:0] n_disconnect_start;
    logic              n_offline_confirmed;
    logic              n_replay_running;
    logic              n_replay_open;
    logic [TIME_W-1:0] n_phase_start;

    // Results produced by the item at the port, and how many of them.
    t_result           res0;
    t_result           res1;
    logic [1:0]        res_n;

    logic              s_xfer;
    logic [TIME_W-1:0] ds_eff;
    logic [TIME_W-1:0] down_ms;
    logic              confirm_now;
    logic [COIL_W-1:0] target_coil;
    logic [TIME_W-1:0] phase_elapsed;
    logic [TIME_W-1:0] phase_limit;
    logic              phase_due;

    assign s_xfer      = i_s_axis_tvalid && o_s_axis_tready;
    assign target_coil = r_bypass_active ? r_bypass_coil : r_main_coil;

    // A fresh outage stamps its start with the current time. A start stamped
    // at zero means no countdown, so such an outage is never confirmed.
    assign ds_eff      = r_prev_link_up ? in_now : r_disconnect_start;
    assign down_ms     = in_now - ds_eff;
    assign confirm_now = !r_offline_confirmed && (ds_eff != '0) && (down_ms >= r_confirm_ms);

    // Phase timing uses the state left by earlier items. On the item that
    // confirms offline a new replay starts closed, timed from that item, and
    // the confirmation takes priority, so no phase change can fall on that item.
    assign phase_elapsed = in_now - r_phase_start;
    assign phase_limit   = TIME_W'(r_replay_open ? r_spray_ms : r_stop_ms);
    assign phase_due     = r_replay_running && (r_spray_ms != '0) && (r_stop_ms != '0) &&
                           (phase_elapsed >= phase_limit);

    always_comb begin
        n_prev_link_up      = r_prev_link_up;
        n_disconnect_start  = r_disconnect_start;
        n_offline_confirmed = r_offline_confirmed;
        n_replay_running    = r_replay_running;
        n_replay_open       = r_replay_open;
        n_phase_start       = r_phase_start;
        res0                = '0;
        res1                = '0;
        res_n               = 2'd0;

        if (in_op == OP_SERVER_CMD) begin
            // A server command is forwarded as it is and halts the replay.
            n_replay_running = 1'b0;
            res0             = '{coil_index: in_cmd_coil, coil_on: in_cmd_on, last: 1'b1};
            res_n            = 2'd1;
        end else if (in_link_up) begin
            if (!r_prev_link_up) begin
                n_replay_running = 1'b0;
            end
            n_disconnect_start  = '0;
            n_offline_confirmed = 1'b0;
            n_prev_link_up      = 1'b1;
        end else begin
            n_disconnect_start = ds_eff;
            n_prev_link_up     = 1'b0;
            if (confirm_now) begin
                // Fogging valve shut first, then, if replay is enabled, the replay target closed.
                n_offline_confirmed = 1'b1;
                res0 = '{coil_index: r_fog_coil, coil_on: 1'b0, last: !r_replay_enable};
                if (r_replay_enable) begin
                    n_replay_running = 1'b1;
                    n_replay_open    = 1'b0;
                    n_phase_start    = in_now;
                    res1  = '{coil_index: target_coil, coil_on: 1'b0, last: 1'b1};
                    res_n = 2'd2;
                end else begin
                    n_replay_running = 1'b0;
                    res_n            = 2'd1;
                end
            end else if (phase_due) begin
                n_replay_open = !r_replay_open;
                n_phase_start = in_now;
                res0  = '{coil_index: target_coil, coil_on: !r_replay_open, last: 1'b1};
                res_n = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_link_up      <= 1'b1;
            r_disconnect_start  <= '0;
            r_offline_confirmed <= 1'b0;
            r_replay_running    <= 1'b0;
            r_replay_open       <= 1'b0;
            r_phase_start       <= '0;
        end else if (s_xfer) begin
            r_prev_link_up      <= n_prev_link_up;
            r_disconnect_start  <= n_disconnect_start;
            r_offline_confirmed <= n_offline_confirmed;
            r_replay_running    <= n_replay_running;
            r_replay_open       <= n_replay_open;
            r_phase_start       <= n_phase_start;
        end
    end

    // ------------------------------------------------------------------
    // Result queue. Four entries, head at entry zero. An input transfer is
    // taken while at most one result waits, so both results of a
    // confirmation always fit, and the master side never throttles the
    // slave side combinationally.
    // ------------------------------------------------------------------
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    t_result    r_q [4];
    t_result    n_q [4];
    logic       m_xfer;
    logic [1:0] wr_idx;

    assign o_s_axis_tready = (r_cnt <= 3'd1);
    assign o_m_axis_tvalid = (r_cnt != 3'd0);
    assign m_xfer          = o_m_axis_tvalid && i_m_axis_tready;
    assign o_m_axis_tdata  = M_TDATA_W'({r_q[0].coil_on, r_q[0].coil_index});
    assign o_m_axis_tlast  = r_q[0].last;

    always_comb begin
        n_q    = r_q;
        n_cnt  = r_cnt;
        wr_idx = 2'd0;
        if (m_xfer) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
            n_q[2] = r_q[3];
            n_cnt  = r_cnt - 3'd1;
        end
        if (s_xfer) begin
            wr_idx = n_cnt[1:0];
            if (res_n != 2'd0) begin
                n_q[wr_idx] = res0;
            end
            if (res_n == 2'd2) begin
                n_q[wr_idx + 2'd1] = res1;
            end
            n_cnt = n_cnt + 3'(res_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    `OFVC_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= 3'd3)
    `OFVC_ASSERT_NXT(a_cmd_gives_result, i_clk, i_rst_n,
        s_xfer && (in_op == OP_SERVER_CMD), o_m_axis_tvalid)
    `OFVC_ASSERT_IMP(a_confirm_queues_fog, i_clk, i_rst_n,
        $rose(r_offline_confirmed), o_m_axis_tvalid)
    `OFVC_ASSERT_NXT(a_cmd_stops_replay, i_clk, i_rst_n,
        s_xfer && (in_op == OP_SERVER_CMD), !r_replay_running)
    `OFVC_ASSERT_IMP(a_pair_fits, i_clk, i_rst_n,
        s_xfer && (res_n == 2'd2), n_cnt <= 3'd3)

endmodule
